/* src/ole_pkg.sv */
// Package for the ordered list engine: request and status codes,
// and the structs that pass control and chain signals to the list cells.
// No dependencies.
package ole_pkg;

   // request modes
   localparam logic [1:0] MODE_APPEND = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam int DATA_W = 32;
   localparam int POS_W  = 8;

   // control broadcast to every cell
   typedef struct packed {
      logic              capture;
      logic [1:0]        cap_mode;
      logic [DATA_W-1:0] cap_value;
      logic [POS_W-1:0]  cap_pos;
      logic              exec;
      logic [1:0]        exec_mode;
      logic [DATA_W-1:0] exec_value;
   } cell_ctrl_type;

   // signals rippling from the head of the list towards the tail
   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] acc;
   } chain_type;

endpackage

/* src/ole_cell.sv */
// One list cell: holds a single entry, compares it with the request and
// shifts in its tail-side neighbour's entry on a remove. Uses ole_pkg.
module ole_cell #(
   parameter int IDX = 0,
   parameter int CW  = 5
) (
   input  logic                       clock,
   input  ole_pkg::cell_ctrl_type     ctrl,
   input  logic [CW-1:0]              count,
   input  logic [ole_pkg::DATA_W-1:0] next_data,
   input  ole_pkg::chain_type         chain_prev,
   output ole_pkg::chain_type         chain_next,
   output logic [ole_pkg::DATA_W-1:0] data
);

   localparam logic [CW-1:0] IDX_C  = CW'(IDX);
   localparam logic [8:0]    IDX_P1 = 9'(IDX + 1);

   logic [ole_pkg::DATA_W-1:0] data_ff;
   logic [ole_pkg::DATA_W-1:0] data_in;
   logic                       match_ff;
   logic                       match_in;
   logic                       occupied;

   assign occupied = IDX_C < count;
   assign data     = data_ff;

   // compare this entry against the incoming request
   always_comb begin
      if (ctrl.cap_mode == ole_pkg::MODE_REMOVE) begin
         match_in = occupied && (data_ff == ctrl.cap_value);
      end else begin
         match_in = occupied && (IDX_P1 == {1'b0, ctrl.cap_pos});
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         match_ff <= match_in;
      end
   end

   // ripple the first-match flag and the selected entry towards the tail
   assign chain_next.hit = chain_prev.hit | match_ff;
   assign chain_next.acc = chain_prev.acc | (match_ff ? data_ff : '0);

   // write on append at the tail, shift on remove from the match towards the tail
   always_comb begin
      data_in = data_ff;
      if (ctrl.exec) begin
         unique case (ctrl.exec_mode)
            ole_pkg::MODE_APPEND: begin
               if (count == IDX_C) begin
                  data_in = ctrl.exec_value;
               end
            end
            ole_pkg::MODE_REMOVE: begin
               if (chain_next.hit) begin
                  data_in = next_data;
               end
            end
            default: begin
               data_in = data_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* src/ordered_list_engine_top.sv */
// Ordered list engine: a row of CAPACITY cells, one entry each.
// A taken request is compared in the cells, then its result is registered for output.
// No new request is taken during the update phase or while the output item waits.
// Reset clears the count, so the list starts empty; entries are not cleared.
// Uses ole_pkg and ole_cell.
module ordered_list_engine_top #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // value[31:0], position[39:32]
   input  logic [1:0]  req_tuser,  // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // status[1:0], read_data[33:2], count[38:34],
                                   // is_empty[39]
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic          busy_ff, busy_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    mode_ff;
   logic [31:0]   value_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [39:0]   rsp_data_ff, rsp_data_in;
   logic          accept;
   logic          full;
   logic          found;
   logic [1:0]    status;
   logic [31:0]   rdata;

   ole_pkg::cell_ctrl_type ctrl;
   ole_pkg::chain_type     chain_w [CAPACITY+1];
   logic [31:0]            cell_data [CAPACITY];

   assign req_tready = !busy_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // broadcast control to the cells
   assign ctrl.capture    = accept;
   assign ctrl.cap_mode   = req_tuser;
   assign ctrl.cap_value  = req_tdata[31:0];
   assign ctrl.cap_pos    = req_tdata[39:32];
   assign ctrl.exec       = busy_ff;
   assign ctrl.exec_mode  = mode_ff;
   assign ctrl.exec_value = value_ff;

   assign chain_w[0].hit = 1'b0;
   assign chain_w[0].acc = '0;

   // the row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [31:0] nxt;
      if (i == CAPACITY - 1) begin : g_last
         assign nxt = cell_data[i];
      end else begin : g_mid
         assign nxt = cell_data[i+1];
      end
      ole_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .next_data  (nxt),
         .chain_prev (chain_w[i]),
         .chain_next (chain_w[i+1]),
         .data       (cell_data[i])
      );
   end

   assign full  = count_ff == CAP_C;
   assign found = chain_w[CAPACITY].hit;

   // work out the result and the new count
   always_comb begin
      count_in = count_ff;
      status   = ole_pkg::STATUS_OK;
      rdata    = '0;
      unique case (mode_ff)
         ole_pkg::MODE_APPEND: begin
            if (full) begin
               status = ole_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         ole_pkg::MODE_REMOVE: begin
            if (found) begin
               count_in = count_ff - CW'(1);
            end else begin
               status = ole_pkg::STATUS_MISS;
            end
         end
         ole_pkg::MODE_READ: begin
            if (found) begin
               rdata = chain_w[CAPACITY].acc;
            end else begin
               status = ole_pkg::STATUS_MISS;
            end
         end
         default: begin
            count_in = '0;
         end
      endcase
      if (!busy_ff) begin
         count_in = count_ff;
      end
   end

   // load the output item after the update phase and hold it until taken
   always_comb begin
      busy_in      = accept;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (busy_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(count_in == '0), 5'(count_in), rdata, status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_tuser;
         value_ff <= req_tdata[31:0];
      end
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("update phase lasted more than one cycle");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted item did not enter the update phase");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> rsp_valid_ff)
      else $error("update phase gave no output item");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("entry count above capacity");
`endif

endmodule
